// ===== rtl/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rsa_pkg: shared definitions for the record slot allocator
// Holds the status and command codes, the record overhead and the
// default sizes used by the allocator and its free-slot finder.
// ----------------------------------------------------------------------------
package rsa_pkg;

    // Default number of slots in the table.
    localparam int SLOTS_DEFAULT = 256;

    // Slots searched per group in the first level of the free-slot finder.
    localparam int GROUP_SIZE = 16;
    localparam int GROUP_W    = 4;

    // Header bytes added to every record on top of key and value.
    localparam int RECORD_OVERHEAD = 16;

    // Value of data_start after reset.
    localparam logic [31:0] DATA_START_RESET = 32'd4096;

    // Field widths.
    localparam int OFFSET_W = 32;
    localparam int SIZE_W   = 18;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_FREE     = 3'd3,
        STAT_OVERFLOW = 3'd4
    } status_t;

endpackage

// ===== rtl/record_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// record_slot_allocator: slot table allocator for variable-size records
// Inserts reuse the first free slot if it is large enough, else append a new slot at
// the running end offset if room remains; deletes free an in-use slot by index.
// ----------------------------------------------------------------------------
// Result: the strobe done is registered from the execute state, which follows the
// search and read states, and is high for exactly one cycle; the receiver cannot stall it.
// A new command is accepted only while idle, after the previous one has passed the
// two-level free-slot search, the read of the offset/size memory and the execute state.
// Reset: control state and in-use flags reset at once, no clearing pass;
// offset/size memory contents are undefined until a slot is appended.
module record_slot_allocator #(
    parameter int SLOTS = rsa_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Command channel
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [15:0] key_length,
    input  logic [15:0] value_length,
    input  logic [7:0]  slot_index,
    // Result channel
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  slot,
    output logic [31:0] record_offset,
    output logic [17:0] record_size,
    output logic        reused,
    // Configuration channel (data_start)
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int EXT_W  = (CNT_W > 8) ? CNT_W : 8;
    localparam int OFF_W  = rsa_pkg::OFFSET_W;
    localparam int SIZE_W = rsa_pkg::SIZE_W;
    localparam int MEM_W  = OFF_W + SIZE_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FIND = 4'b0010,
        S_READ = 4'b0100,
        S_EXEC = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                cmd_reg;
    logic [SIZE_W-1:0]   need_reg;
    logic [SIZE_W-1:0]   need_next;
    logic [7:0]          idx_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [OFF_W-1:0]    next_offset_reg;
    logic [SLOTS-1:0]    in_use_reg;

    logic                done_reg;
    rsa_pkg::status_t    status_reg;
    logic [7:0]          slot_reg;
    logic [OFF_W-1:0]    offset_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic                reused_reg;

    logic [MEM_W-1:0]    slot_mem [SLOTS];
    logic [MEM_W-1:0]    rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;

    logic                ff_found;
    logic [IDX_W-1:0]    ff_index;

    logic [OFF_W-1:0]    mem_offset;
    logic [SIZE_W-1:0]   mem_size;
    logic [OFF_W:0]      sum_end;
    logic [EXT_W-1:0]    idx_ext;
    logic [IDX_W-1:0]    idx_addr;
    logic [IDX_W-1:0]    append_idx;
    logic                idx_range;
    logic                table_full;
    logic                reuse_ok;
    logic                accept;
    logic                cfg_write;

    rsa_pkg::status_t    res_status;
    logic [EXT_W-1:0]    res_slot;
    logic [OFF_W-1:0]    res_offset;
    logic [SIZE_W-1:0]   res_size;
    logic                res_reused;
    logic                res_append;
    logic                mem_we;
    logic                set_use;
    logic                clr_use;
    logic [IDX_W-1:0]    use_addr;

    // Handshakes.
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    // Record size is fixed at acceptance.
    assign need_next = SIZE_W'(key_length) + SIZE_W'(value_length)
                     + SIZE_W'(rsa_pkg::RECORD_OVERHEAD);

    // Lowest free slot among the in-use flags; slots never allocated read as used.
    rsa_free_finder #(
        .SLOTS (SLOTS)
    ) u_finder (
        .clk      (clk),
        .free_vec (~in_use_reg),
        .found    (ff_found),
        .index    (ff_index)
    );

    // Sequencer: search, read the slot entry, then execute.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_FIND;
            S_FIND:  state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Index decoding and arithmetic for the execute cycle.
    assign idx_ext    = EXT_W'(idx_reg);
    assign idx_addr   = idx_ext[IDX_W-1:0];
    assign idx_range  = (idx_ext >= EXT_W'(count_reg));
    assign append_idx = count_reg[IDX_W-1:0];
    assign table_full = (count_reg == CNT_W'(SLOTS));
    assign mem_offset = rd_data_reg[MEM_W-1:SIZE_W];
    assign mem_size   = rd_data_reg[SIZE_W-1:0];
    assign sum_end    = {1'b0, next_offset_reg} + (OFF_W + 1)'(need_reg);
    assign reuse_ok   = ff_found && (need_reg <= mem_size);
    assign rd_addr    = (cmd_reg == rsa_pkg::CMD_DELETE) ? idx_addr : ff_index;

    // Command decision.
    always_comb
    begin
        res_status = rsa_pkg::STAT_OK;
        res_slot   = '0;
        res_offset = '0;
        res_size   = '0;
        res_reused = 1'b0;
        res_append = 1'b0;
        mem_we     = 1'b0;
        set_use    = 1'b0;
        clr_use    = 1'b0;
        use_addr   = append_idx;
        if (cmd_reg == rsa_pkg::CMD_INSERT)
        begin
            if (reuse_ok)
            begin
                res_slot   = EXT_W'(ff_index);
                res_offset = mem_offset;
                res_size   = mem_size;
                res_reused = 1'b1;
                set_use    = 1'b1;
                use_addr   = ff_index;
            end
            else if (table_full)
            begin
                res_status = rsa_pkg::STAT_FULL;
            end
            else if (sum_end[OFF_W])
            begin
                res_status = rsa_pkg::STAT_OVERFLOW;
            end
            else
            begin
                res_slot   = EXT_W'(append_idx);
                res_offset = next_offset_reg;
                res_size   = need_reg;
                res_append = 1'b1;
                mem_we     = 1'b1;
                set_use    = 1'b1;
            end
        end
        else
        begin
            if (idx_range)
            begin
                res_status = rsa_pkg::STAT_RANGE;
            end
            else if (!in_use_reg[idx_addr])
            begin
                res_status = rsa_pkg::STAT_FREE;
            end
            else
            begin
                res_slot   = idx_ext;
                res_offset = mem_offset;
                res_size   = mem_size;
                clr_use    = 1'b1;
                use_addr   = idx_addr;
            end
        end
    end

    // Offset/size memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && mem_we)
        begin
            slot_mem[append_idx] <= {next_offset_reg, need_reg};
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    // Control state, table bookkeeping and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            next_offset_reg <= rsa_pkg::DATA_START_RESET;
            in_use_reg      <= '1;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
            // A new data_start moves the end offset only while the table is empty.
            if (cfg_write)
            begin
                if (count_reg == '0)
                begin
                    next_offset_reg <= cfg_data;
                end
            end
            if (state_reg == S_EXEC)
            begin
                if (set_use)
                begin
                    in_use_reg[use_addr] <= 1'b1;
                end
                if (clr_use)
                begin
                    in_use_reg[use_addr] <= 1'b0;
                end
                if (res_append)
                begin
                    count_reg       <= count_reg + CNT_W'(1);
                    next_offset_reg <= sum_end[OFF_W-1:0];
                end
            end
        end
    end

    // Command beat capture and result registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            need_reg <= need_next;
            idx_reg  <= slot_index;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg <= res_status;
            slot_reg   <= res_slot[7:0];
            offset_reg <= res_offset;
            size_reg   <= res_size;
            reused_reg <= res_reused;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign record_offset = offset_reg;
    assign record_size   = size_reg;
    assign reused        = reused_reg;

`ifndef NO_ASSERTIONS
    // A result beat only follows the execute cycle.
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EXEC))
        else $error("result strobe without execute cycle");

    // The slot count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("slot count beyond table size");

    // A failed command reports zero payload.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != rsa_pkg::STAT_OK) |->
            (slot_reg == '0 && offset_reg == '0 && size_reg == '0 && !reused_reg))
        else $error("failed command with nonzero payload");

    // An accepted command starts the search.
    a_accept_find: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_FIND))
        else $error("accepted command did not start search");

    // Reuse is only reported for a successful insert.
    a_reuse_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && reused_reg) |->
            (status_reg == rsa_pkg::STAT_OK && cmd_reg == rsa_pkg::CMD_INSERT))
        else $error("reuse flagged on non-insert or failure");
`endif

endmodule

// ===== rtl/rsa_free_finder.sv =====
// ----------------------------------------------------------------------------
// rsa_free_finder: two-level registered search for the lowest free slot
// The first level encodes each group of slots and registers the result;
// the second level picks the lowest group that holds a free slot.
// ----------------------------------------------------------------------------
module rsa_free_finder #(
    parameter int SLOTS = rsa_pkg::SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic [SLOTS-1:0]           free_vec,
    output logic                       found,
    output logic [$clog2(SLOTS)-1:0]   index
);

    localparam int GROUP = rsa_pkg::GROUP_SIZE;
    localparam int SUB_W = rsa_pkg::GROUP_W;
    localparam int NG    = (SLOTS + GROUP - 1) / GROUP;
    localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
    localparam int PAD_W = NG * GROUP;
    localparam int IDX_W = $clog2(SLOTS);

    logic [PAD_W-1:0]  free_pad;
    logic [NG-1:0]     grp_any_next;
    logic [NG-1:0]     grp_any_reg;
    logic [SUB_W-1:0]  grp_sub_next [NG];
    logic [SUB_W-1:0]  grp_sub_reg  [NG];
    logic              found_next;
    logic              found_reg;
    logic [GW+SUB_W-1:0] index_next;
    logic [IDX_W-1:0]  index_reg;

    // Pad the free vector to whole groups; padding slots are never free.
    assign free_pad = PAD_W'(free_vec);

    // First level: lowest free slot within each group.
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_any_next[g] = |free_pad[g*GROUP +: GROUP];
            grp_sub_next[g] = '0;
            for (int i = GROUP - 1; i >= 0; i--)
            begin
                if (free_pad[g*GROUP + i])
                begin
                    grp_sub_next[g] = SUB_W'(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_any_reg <= grp_any_next;
        grp_sub_reg <= grp_sub_next;
    end

    // Second level: lowest group that has a free slot.
    always_comb
    begin
        found_next = |grp_any_reg;
        index_next = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                index_next = {GW'(g), grp_sub_reg[g]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        index_reg <= index_next[IDX_W-1:0];
    end

    assign found = found_reg;
    assign index = index_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the record slot allocator
// Drives insert and delete commands with random spacing, keeps a private
// copy of the slot table to predict every result beat, and compares each
// beat field by field. data_start is rewritten only while the block idles.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_SLOTS   = rsa_pkg::SLOTS_DEFAULT;
    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE_PAD  = 8;
    localparam int MAX_REPORTS = 10;

    // One predicted result beat.
    typedef struct packed {
        rsa_pkg::status_t status;
        logic [7:0]       slot;
        logic [31:0]      offset;
        logic [17:0]      size;
        logic             reused;
    } alloc_result_t;

    // Slot table predictor and result scoreboard.
    class slot_table_sb;
        logic [31:0]   data_start;
        bit            in_use [NUM_SLOTS];
        logic [31:0]   offs [NUM_SLOTS];
        logic [17:0]   sizes [NUM_SLOTS];
        int            count;
        logic [31:0]   next_off;
        alloc_result_t pending_q [$];
        int            errors;
        int            checked;
        int            status_hits [5];
        int            reuse_hits;
        int            append_hits;

        function new();
            data_start = rsa_pkg::DATA_START_RESET;
            count      = 0;
            next_off   = rsa_pkg::DATA_START_RESET;
            errors     = 0;
            checked    = 0;
            reuse_hits = 0;
            append_hits = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        // The register always updates; the end offset follows only while empty.
        function void note_config(logic [31:0] v);
            data_start = v;
            if (count == 0)
                next_off = v;
        endfunction

        // Work out the result beat for one accepted command.
        function void note_command(logic cmd, logic [15:0] kl, logic [15:0] vl,
                                   logic [7:0] idx);
            alloc_result_t r;
            logic [17:0]   need;
            logic [32:0]   end_off;
            int            f;
            r = '0;
            if (cmd == rsa_pkg::CMD_INSERT)
            begin
                need = {2'b00, kl} + {2'b00, vl} + 18'(rsa_pkg::RECORD_OVERHEAD);
                // Only the lowest free slot is a reuse candidate.
                f = -1;
                for (int i = 0; i < count; i++)
                begin
                    if (!in_use[i])
                    begin
                        f = i;
                        break;
                    end
                end
                if (f >= 0 && need <= sizes[f])
                begin
                    in_use[f] = 1'b1;
                    r.slot    = f[7:0];
                    r.offset  = offs[f];
                    r.size    = sizes[f];
                    r.reused  = 1'b1;
                    reuse_hits++;
                end
                else if (count >= NUM_SLOTS)
                begin
                    r.status = rsa_pkg::STAT_FULL;
                end
                else
                begin
                    end_off = {1'b0, next_off} + {15'd0, need};
                    if (end_off > 33'h0_FFFF_FFFF)
                    begin
                        r.status = rsa_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        in_use[count] = 1'b1;
                        offs[count]   = next_off;
                        sizes[count]  = need;
                        r.slot        = count[7:0];
                        r.offset      = next_off;
                        r.size        = need;
                        count++;
                        next_off = end_off[31:0];
                        append_hits++;
                    end
                end
            end
            else
            begin
                if (int'(idx) >= count)
                begin
                    r.status = rsa_pkg::STAT_RANGE;
                end
                else if (!in_use[idx])
                begin
                    r.status = rsa_pkg::STAT_FREE;
                end
                else
                begin
                    in_use[idx] = 1'b0;
                    r.slot      = idx;
                    r.offset    = offs[idx];
                    r.size      = sizes[idx];
                end
            end
            status_hits[r.status]++;
            pending_q.push_back(r);
        endfunction

        // Compare one result beat against the oldest prediction.
        function void check_result(logic [2:0] st, logic [7:0] sl, logic [31:0] off,
                                   logic [17:0] sz, logic ru);
            alloc_result_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result beat with nothing pending: status %0d slot %0d",
                             $realtime, st, sl);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (want.status !== st || want.slot !== sl || want.offset !== off ||
                want.size !== sz || want.reused !== ru)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t: mismatch on result %0d", $realtime, checked);
                    $display("  expected status %0d slot %0d offset %h size %0d reused %0d",
                             want.status, want.slot, want.offset, want.size, want.reused);
                    $display("  actual   status %0d slot %0d offset %h size %0d reused %0d",
                             st, sl, off, sz, ru);
                end
            end
        endfunction

        // Random slot that is currently allocated, or -1 if none is.
        function int pick_used_slot();
            int first;
            int k;
            if (count == 0)
                return -1;
            first = $urandom_range(count - 1, 0);
            for (int i = 0; i < count; i++)
            begin
                k = (first + i) % count;
                if (in_use[k])
                    return k;
            end
            return -1;
        endfunction

        function void finish_check();
            if (pending_q.size() != 0)
            begin
                errors += pending_q.size();
                $display("%0d predicted result beats never arrived", pending_q.size());
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        command = rsa_pkg::CMD_INSERT;
    logic [15:0] key_length = 16'd0;
    logic [15:0] value_length = 16'd0;
    logic [7:0]  slot_index = 8'd0;
    logic        done;
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [31:0] record_offset;
    logic [17:0] record_size;
    logic        reused;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'd0;

    slot_table_sb sb = new();
    bit           start_held = 1'b0;
    int           burst_left = 0;
    int           sent = 0;
    int           idle_count = 0;
    logic [15:0]  base_hi;

    record_slot_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .key_length   (key_length),
        .value_length (value_length),
        .slot_index   (slot_index),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .record_offset(record_offset),
        .record_size  (record_size),
        .reused       (reused),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every result beat is checked at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, slot, record_offset, record_size, reused);
    end

    // Watchdog: ends the run after too many cycles with no beat of any kind.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Mostly short gaps, a few long ones, and now and then a burst with none.
    function automatic int next_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 3)
        begin
            burst_left = $urandom_range(32, 16);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Length mix: extremes, many small records, some medium and full range.
    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(9, 0);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r < 6)  return 16'($urandom_range(63, 0));
        if (r < 8)  return 16'($urandom_range(4095, 0));
        return 16'($urandom);
    endfunction

    task automatic release_start();
        if (start_held)
        begin
            start <= 1'b0;
            start_held = 1'b0;
        end
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            release_start();
            repeat (n) @(posedge clk);
        end
    endtask

    // Present one command and hold it until the block takes the beat.
    task automatic send_command(input logic cmd, input logic [15:0] kl,
                                input logic [15:0] vl, input logic [7:0] idx);
        start        <= 1'b1;
        command      <= cmd;
        key_length   <= kl;
        value_length <= vl;
        slot_index   <= idx;
        start_held = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_command(cmd, kl, vl, idx);
        sent++;
        idle_cycles(next_gap());
    endtask

    // Unused fields of each command carry random noise.
    task automatic insert_rec(input logic [15:0] kl, input logic [15:0] vl);
        send_command(rsa_pkg::CMD_INSERT, kl, vl, 8'($urandom));
    endtask

    task automatic delete_slot(input logic [7:0] idx);
        send_command(rsa_pkg::CMD_DELETE, 16'($urandom), 16'($urandom), idx);
    endtask

    // Wait until every predicted beat has come back, then a few more cycles.
    task automatic settle();
        release_start();
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE_PAD) @(posedge clk);
    endtask

    task automatic write_data_start(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.note_config(v);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One random command; deletes mostly target allocated slots.
    task automatic random_command(input int insert_pct);
        int u;
        if ($urandom_range(99, 0) < insert_pct)
        begin
            insert_rec(pick_length(), pick_length());
        end
        else
        begin
            u = sb.pick_used_slot();
            if (u >= 0 && $urandom_range(9, 0) < 7)
                delete_slot(u[7:0]);
            else
                delete_slot(8'($urandom));
        end
    endtask

    initial
    begin
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: deletes are out of range at both ends of the index.
        delete_slot(8'd0);
        delete_slot(8'd255);
        settle();

        // Storage starting at the very top overflows for any record.
        write_data_start(32'hFFFF_FFFF);
        insert_rec(16'd0, 16'd0);
        insert_rec(16'hFFFF, 16'hFFFF);
        settle();
        // The smallest record ends one byte past the top of the store.
        write_data_start(32'hFFFF_FFF0);
        insert_rec(16'd0, 16'd0);
        settle();

        // Lowest base, then a random base with room for a full table.
        write_data_start(32'd0);
        base_hi = 16'($urandom_range(16'hEFFF, 0));
        write_data_start({base_hi, 16'h0000});

        // Appends with the length extremes.
        insert_rec(16'd0, 16'd0);
        insert_rec(16'hFFFF, 16'hFFFF);
        insert_rec(16'hFFFF, 16'd0);
        insert_rec(16'd0, 16'hFFFF);
        insert_rec(16'd5, 16'd7);
        // Free a slot, free it again, and delete just past the end and at the top index.
        delete_slot(8'd1);
        delete_slot(8'd1);
        delete_slot(8'd5);
        delete_slot(8'd255);
        // A record of exactly the freed size reuses the slot.
        insert_rec(16'hFFFF, 16'hFFFF);
        delete_slot(8'd0);
        delete_slot(8'd2);
        // First free slot is one byte short: append although a later slot fits.
        insert_rec(16'd0, 16'd1);
        insert_rec(16'd0, 16'd0);
        // Reuse keeps the old, larger size.
        insert_rec(16'd100, 16'd100);
        settle();

        // With slots allocated a new base must not move the end offset.
        write_data_start(32'hFFFF_FFFF);
        insert_rec(16'd1, 16'd2);
        settle();

        // Insert-heavy traffic until every slot has been appended, for at most 1500 commands.
        n = 0;
        while (sb.count < NUM_SLOTS && n < 1500)
        begin
            random_command(80);
            n++;
        end
        settle();
        write_data_start(32'($urandom));

        // Balanced traffic against a full table.
        for (int i = 0; i < 150; i++)
            random_command(50);
        settle();

        sb.finish_check();
        $display("%0d commands, %0d results checked, %0d slots allocated",
                 sent, sb.checked, sb.count);
        $display("appends %0d, reuses %0d, frees %0d, full %0d, overflow %0d,",
                 sb.append_hits, sb.reuse_hits,
                 sb.status_hits[rsa_pkg::STAT_OK] - sb.append_hits - sb.reuse_hits,
                 sb.status_hits[rsa_pkg::STAT_FULL],
                 sb.status_hits[rsa_pkg::STAT_OVERFLOW]);
        $display("  range %0d, double free %0d",
                 sb.status_hits[rsa_pkg::STAT_RANGE], sb.status_hits[rsa_pkg::STAT_FREE]);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
